// File: hw/rtl/ac_phase_dimmer_two_channel_macros.svh
// Assertion macros shared by the dimmer checker.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef AC_PHASE_DIMMER_TWO_CHANNEL_MACROS_SVH
`define AC_PHASE_DIMMER_TWO_CHANNEL_MACROS_SVH

// Same-cycle implication.
`define ACPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ACPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ac_pd_pkg.sv
// ----------------------------------------------------------------------------
// ac_pd_pkg
// Shared types and constants of the two-channel phase-angle dimmer.
// ----------------------------------------------------------------------------
package ac_pd_pkg;

  localparam int TIME_WIDTH_DEF  = 14;
  localparam int PULSE_WIDTH_DEF = 8;

  localparam int IDX_W       = 3;
  localparam int CFG_W       = 14;
  localparam int BRIGHT_W    = 7;
  localparam int HOLD_W      = 14;
  localparam int PULSE_CFG_W = 8;
  localparam int DLY_W       = 14;

  localparam logic [BRIGHT_W-1:0]    BRIGHT_MAX      = 7'd100;
  localparam logic [HOLD_W-1:0]      HOLDOFF_RST     = 14'd8500;
  localparam logic [PULSE_CFG_W-1:0] GATE_PULSE_RST  = 8'd10;
  localparam logic [DLY_W-1:0]       DLY_LONGEST_RST = 14'd8600;
  localparam logic [DLY_W-1:0]       DLY_SHORT_RST   = 14'd500;

  // Input stages ahead of the processing stage; covers the delay pipeline.
  localparam int PIPE_DEPTH = 3;

  // Exact divide by 99 for m < 2**21: floor(m * ceil(2**28 / 99) / 2**28).
  localparam int MAG_W     = BRIGHT_W + DLY_W;
  localparam int DIV_SHIFT = 28;
  localparam int RECIP_W   = 22;
  localparam int PROD_W    = MAG_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 22'd2711470;

  typedef enum logic [IDX_W-1:0] {
    CFG_BRIGHT_CH1   = 3'd0,
    CFG_BRIGHT_CH2   = 3'd1,
    CFG_ZC_HOLDOFF   = 3'd2,
    CFG_GATE_PULSE   = 3'd3,
    CFG_DLY_LONGEST  = 3'd4,
    CFG_DLY_SHORTEST = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [BRIGHT_W-1:0]    bright_ch1;
    logic [BRIGHT_W-1:0]    bright_ch2;
    logic [HOLD_W-1:0]      zc_holdoff;
    logic [PULSE_CFG_W-1:0] gate_pulse;
    logic [DLY_W-1:0]       dly_longest;
    logic [DLY_W-1:0]       dly_shortest;
  } cfg_t;

  typedef logic [DLY_W-1:0] dly_t;

endpackage

// File: hw/rtl/ac_pd_cfg_regs.sv
// ----------------------------------------------------------------------------
// ac_pd_cfg_regs
// Configuration register file with brightness saturation.
// ----------------------------------------------------------------------------
module ac_pd_cfg_regs import ac_pd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output cfg_t             cfg_o
);

  cfg_t                cfg_d, cfg_q;
  logic [BRIGHT_W-1:0] bright_raw, bright_sat;

  assign bright_raw = cfg_wdata_i[BRIGHT_W-1:0];
  assign bright_sat = (bright_raw > BRIGHT_MAX) ? BRIGHT_MAX : bright_raw;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BRIGHT_CH1:   cfg_d.bright_ch1   = bright_sat;
        CFG_BRIGHT_CH2:   cfg_d.bright_ch2   = bright_sat;
        CFG_ZC_HOLDOFF:   cfg_d.zc_holdoff   = cfg_wdata_i[HOLD_W-1:0];
        CFG_GATE_PULSE:   cfg_d.gate_pulse   = cfg_wdata_i[PULSE_CFG_W-1:0];
        CFG_DLY_LONGEST:  cfg_d.dly_longest  = cfg_wdata_i[DLY_W-1:0];
        CFG_DLY_SHORTEST: cfg_d.dly_shortest = cfg_wdata_i[DLY_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bright_ch1   <= '0;
      cfg_q.bright_ch2   <= '0;
      cfg_q.zc_holdoff   <= HOLDOFF_RST;
      cfg_q.gate_pulse   <= GATE_PULSE_RST;
      cfg_q.dly_longest  <= DLY_LONGEST_RST;
      cfg_q.dly_shortest <= DLY_SHORT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/ac_pd_delay_calc.sv
// ----------------------------------------------------------------------------
// ac_pd_delay_calc
// Three-stage firing delay: L + trunc((b - 1) * (S - L) / 99), 0 when b is 0.
// ----------------------------------------------------------------------------
module ac_pd_delay_calc import ac_pd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [BRIGHT_W-1:0] bright_i,
  input  logic [DLY_W-1:0]    dly_longest_i,
  input  logic [DLY_W-1:0]    dly_shortest_i,
  output dly_t                delay_o
);

  logic [DLY_W:0]      diff, diff_abs;
  logic                diff_neg;
  logic [BRIGHT_W-1:0] bright_m1;
  logic [MAG_W-1:0]    mag_d, mag_q;
  logic                neg_a_q, zero_a_q;
  logic [PROD_W-1:0]   prod_d, prod_q;
  logic                neg_b_q, zero_b_q;
  logic [DLY_W-1:0]    quot;
  dly_t                delay_d, delay_q;

  // Stage A: magnitude of the numerator, sign kept aside.
  assign diff      = {1'b0, dly_shortest_i} - {1'b0, dly_longest_i};
  assign diff_neg  = diff[DLY_W];
  assign diff_abs  = diff_neg ? (~diff + 1'b1) : diff;
  assign bright_m1 = bright_i - 1'b1;
  assign mag_d     = MAG_W'(bright_m1) * MAG_W'(diff_abs[DLY_W-1:0]);

  // Stage B: divide by 99 through the reciprocal.
  assign prod_d = PROD_W'(mag_q) * PROD_W'(DIV_RECIP);

  // Stage C: apply the truncated quotient with its sign.
  assign quot    = prod_q[DIV_SHIFT +: DLY_W];
  assign delay_d = zero_b_q ? '0 :
                   (neg_b_q ? (dly_longest_i - quot) : (dly_longest_i + quot));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q    <= '0;
      neg_a_q  <= 1'b0;
      zero_a_q <= 1'b1;
      prod_q   <= '0;
      neg_b_q  <= 1'b0;
      zero_b_q <= 1'b1;
      delay_q  <= '0;
    end else begin
      mag_q    <= mag_d;
      neg_a_q  <= diff_neg;
      zero_a_q <= (bright_i == '0);
      prod_q   <= prod_d;
      neg_b_q  <= neg_a_q;
      zero_b_q <= zero_a_q;
      delay_q  <= delay_d;
    end
  end

  assign delay_o = delay_q;

endmodule

// File: hw/rtl/ac_pd_core.sv
// ----------------------------------------------------------------------------
// ac_pd_core
// Tick pipeline, zero-cross filter, phase counters, gate pulses, result beat.
// ----------------------------------------------------------------------------
module ac_pd_core import ac_pd_pkg::*; #(
  parameter int TIME_WIDTH       = TIME_WIDTH_DEF,
  parameter int PULSE_WIDTH_BITS = PULSE_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  dly_t delay_i [2],
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic zero_cross_level_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic gate_one_o,
  output logic gate_two_o,
  output logic zc_accepted_o
);

  localparam int TW     = TIME_WIDTH;
  localparam int PW     = PULSE_WIDTH_BITS;
  localparam int CMP_W  = (TW > HOLD_W) ? TW : HOLD_W;
  localparam int PCMP_W = (PW > PULSE_CFG_W) ? PW : PULSE_CFG_W;
  localparam int LAST   = PIPE_DEPTH - 1;
  localparam logic [TW-1:0] TIME_MAX = {TW{1'b1}};

  logic [PIPE_DEPTH-1:0] stg_vld_q, stg_lvl_q, stg_rdy, stg_vld_in, stg_lvl_in;
  logic                  proc_en, fire, lvl;

  logic          prev_d, prev_q;
  logic [TW-1:0] since_d, since_q, since_inc;
  logic          zc_acc;

  logic [PCMP_W-1:0] gp_ext;
  logic [PW-1:0]     gp;
  logic [1:0]        gate;

  logic out_vld_q;
  logic gate_one_q, gate_two_q, zc_acc_q;

  // Stage handshake: a stage loads when empty or when it hands its beat on.
  assign proc_en = !out_vld_q || out_ready_i;

  always_comb begin
    stg_rdy[LAST] = !stg_vld_q[LAST] || proc_en;
    for (int i = LAST - 1; i >= 0; i--) begin
      stg_rdy[i] = !stg_vld_q[i] || stg_rdy[i+1];
    end
  end

  always_comb begin
    stg_vld_in[0] = in_valid_i;
    stg_lvl_in[0] = zero_cross_level_i;
    for (int i = 1; i < PIPE_DEPTH; i++) begin
      stg_vld_in[i] = stg_vld_q[i-1];
      stg_lvl_in[i] = stg_lvl_q[i-1];
    end
  end

  assign in_ready_o = stg_rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= '0;
    end else begin
      for (int i = 0; i < PIPE_DEPTH; i++) begin
        if (stg_rdy[i]) begin
          stg_vld_q[i] <= stg_vld_in[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < PIPE_DEPTH; i++) begin
      if (stg_rdy[i]) begin
        stg_lvl_q[i] <= stg_lvl_in[i];
      end
    end
  end

  assign fire = stg_vld_q[LAST] && proc_en;
  assign lvl  = stg_lvl_q[LAST];

  // Zero-cross filter: saturate first, then test the edge against the count.
  assign since_inc = (since_q == TIME_MAX) ? since_q : (since_q + 1'b1);
  assign zc_acc    = lvl && !prev_q && (CMP_W'(since_inc) > CMP_W'(cfg_i.zc_holdoff));
  assign since_d   = fire ? (zc_acc ? '0 : since_inc) : since_q;
  assign prev_d    = fire ? lvl : prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b0;
      since_q <= '0;
    end else begin
      prev_q  <= prev_d;
      since_q <= since_d;
    end
  end

  assign gp_ext = PCMP_W'(cfg_i.gate_pulse);
  assign gp     = gp_ext[PW-1:0];

  for (genvar ch = 0; ch < 2; ch++) begin : g_ch
    logic [BRIGHT_W-1:0] bright;
    logic                enabled, restart, armed, hit, load;
    logic [TW-1:0]       cnt, cnt_d, cnt_q;
    logic                armed_d, armed_q;
    logic [PW-1:0]       pulse, pulse_d, pulse_q;

    assign bright  = (ch == 0) ? cfg_i.bright_ch1 : cfg_i.bright_ch2;
    assign enabled = (bright != '0);
    assign restart = zc_acc && enabled;
    assign armed   = armed_q || restart;
    assign cnt     = restart ? '0 : cnt_q;
    assign hit     = CMP_W'(cnt) >= CMP_W'(delay_i[ch]);
    // A disabled channel that fires just disarms.
    assign load    = armed && hit && enabled;
    assign pulse   = load ? gp : pulse_q;
    assign gate[ch] = (pulse != '0);

    always_comb begin
      cnt_d   = cnt_q;
      armed_d = armed_q;
      pulse_d = pulse_q;
      if (fire) begin
        cnt_d   = (armed && !hit && (cnt != TIME_MAX)) ? (cnt + 1'b1) : cnt;
        armed_d = armed && !hit;
        pulse_d = (pulse != '0) ? (pulse - 1'b1) : pulse;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q   <= '0;
        armed_q <= 1'b0;
        pulse_q <= '0;
      end else begin
        cnt_q   <= cnt_d;
        armed_q <= armed_d;
        pulse_q <= pulse_d;
      end
    end
  end

  // Result register: hold the beat until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (proc_en) begin
      out_vld_q <= stg_vld_q[LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      gate_one_q <= gate[0];
      gate_two_q <= gate[1];
      zc_acc_q   <= zc_acc;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign gate_one_o    = gate_one_q;
  assign gate_two_o    = gate_two_q;
  assign zc_accepted_o = zc_acc_q;

endmodule

// File: hw/rtl/ac_phase_dimmer_two_channel.sv
// ----------------------------------------------------------------------------
// ac_phase_dimmer_two_channel
// Two-channel phase-angle TRIAC dimmer driven by one beat per microsecond.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one beat per tick carrying
//   the sampled zero-cross level. Output channel (out_valid_o / out_ready_i)
//   returns one beat per input beat: both gate levels and the zero-cross
//   accept flag, in order.
//   Throughput is one beat per cycle while out_ready_i stays high. A beat
//   passes the three input stages and then lands in the result register; the
//   stage count matches the three-stage firing-delay pipeline, so a delay
//   worked out from freshly written registers is ready by the time the next
//   beat reaches the phase counters.
//   The result register and the input stages fill independently: while the
//   receiver stalls, up to three more beats are taken before in_ready_o drops.
//   Configuration uses cfg_we_i / cfg_index_i / cfg_wdata_i, one write per
//   cycle, with no wait; write only while no beat is in flight.
//   Reset clears the pipeline, counters and pulses and loads the default
//   register values; both channels start disabled.
// ----------------------------------------------------------------------------
module ac_phase_dimmer_two_channel import ac_pd_pkg::*; #(
  parameter int TIME_WIDTH       = TIME_WIDTH_DEF,
  parameter int PULSE_WIDTH_BITS = PULSE_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             zero_cross_level_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             gate_one_o,
  output logic             gate_two_o,
  output logic             zc_accepted_o
);

  cfg_t cfg;
  dly_t delay [2];

  ac_pd_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ac_pd_delay_calc u_delay_ch1 (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bright_i       (cfg.bright_ch1),
    .dly_longest_i  (cfg.dly_longest),
    .dly_shortest_i (cfg.dly_shortest),
    .delay_o        (delay[0])
  );

  ac_pd_delay_calc u_delay_ch2 (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bright_i       (cfg.bright_ch2),
    .dly_longest_i  (cfg.dly_longest),
    .dly_shortest_i (cfg.dly_shortest),
    .delay_o        (delay[1])
  );

  ac_pd_core #(
    .TIME_WIDTH       (TIME_WIDTH),
    .PULSE_WIDTH_BITS (PULSE_WIDTH_BITS)
  ) u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .delay_i            (delay),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .zero_cross_level_i (zero_cross_level_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .gate_one_o         (gate_one_o),
    .gate_two_o         (gate_two_o),
    .zc_accepted_o      (zc_accepted_o)
  );

endmodule

// File: hw/rtl/ac_pd_checker.sv
// ----------------------------------------------------------------------------
// ac_pd_checker
// Port-level checks of the dimmer, bound to the top level.
// ----------------------------------------------------------------------------
`include "ac_phase_dimmer_two_channel_macros.svh"

module ac_pd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic gate_one_o,
  input logic gate_two_o,
  input logic zc_accepted_o
);

  logic       in_beat, out_beat;
  logic [2:0] inflight_q;
  logic       last_zc_q;

  assign in_beat  = in_valid_i && in_ready_o;
  assign out_beat = out_valid_o && out_ready_i;

  // Track beats in flight and the accept flag of the last delivered beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
      last_zc_q  <= 1'b0;
    end else begin
      inflight_q <= inflight_q + {2'b0, in_beat} - {2'b0, out_beat};
      if (out_beat) begin
        last_zc_q <= zc_accepted_o;
      end
    end
  end

  `ACPD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(gate_one_o) && $stable(gate_two_o) && $stable(zc_accepted_o),
    "stalled result beat changed")

  `ACPD_ASSERT_NOW(a_ready_when_empty, !out_valid_o, in_ready_o,
    "input not ready while result register empty")

  `ACPD_ASSERT_NOW(a_no_double_zc, out_valid_o && last_zc_q, !zc_accepted_o,
    "zero-cross accepted on two consecutive beats")

  `ACPD_ASSERT_NOW(a_inflight_bound, 1'b1,
    (inflight_q <= 3'd4) && (!out_valid_o || (inflight_q != 3'd0)),
    "beats in flight out of range")

endmodule

bind ac_phase_dimmer_two_channel ac_pd_checker u_ac_pd_checker (.*);

// File: tb/sv/tb_ac_phase_dimmer_two_channel.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ac_phase_dimmer_two_channel
// Self-checking bench for the two-channel phase-angle dimmer. Ticks of the
// zero-cross level go in through the input handshake. A cycle-true model of
// the edge filter, the phase counters and the gate pulses predicts each result
// beat, and the bench compares the beats in order under random stalls on
// both sides and a series of register settings.
// ----------------------------------------------------------------------------
module tb_ac_phase_dimmer_two_channel;
  import ac_pd_pkg::*;

  localparam int unsigned TIME_MAX    = (1 << TIME_WIDTH_DEF) - 1;
  localparam int unsigned PULSE_MAX   = (1 << PULSE_WIDTH_DEF) - 1;
  localparam int unsigned MAX_GAP     = 8;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned DRAIN_WAIT  = 8;   // three input stages plus result register
  // Longest quiet spell in a correct run is the receiver hold (HOLD_CYCLES)
  // or a phase change; the limit is set well above both.
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned MAX_REPORTS = 40;
  localparam int unsigned NUM_PHASES  = 9;
  localparam int unsigned PHASE_TICKS = 75;

  localparam logic [IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  typedef struct packed {
    logic gate_one;
    logic gate_two;
    logic zc_accepted;
  } tick_out_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             zero_cross_level_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic             gate_one_o;
  logic             gate_two_o;
  logic             zc_accepted_o;

  int unsigned sender_quiet_pct   = 13;
  int unsigned receiver_quiet_pct = 13;
  bit          hold_request       = 1'b0;
  int unsigned settings_run       = 0;

  // --------------------------------------------------------------------------
  // Dimmer model and store of expected result beats
  // --------------------------------------------------------------------------
  class dimmer_scoreboard;
    tick_out_t              pending[$];
    logic [BRIGHT_W-1:0]    bright[2];
    logic [HOLD_W-1:0]      holdoff;
    logic [PULSE_CFG_W-1:0] gate_pulse;
    logic [DLY_W-1:0]       dly_longest;
    logic [DLY_W-1:0]       dly_shortest;
    bit                     prev_level;
    int unsigned            since_edge;
    int unsigned            phase_cnt[2];
    bit                     armed[2];
    int unsigned            pulse_cnt[2];
    int unsigned            errors;
    int unsigned            n_ticks;
    int unsigned            n_edges;
    int unsigned            n_pulses;

    function new();
      bright[0]    = '0;
      bright[1]    = '0;
      holdoff      = HOLDOFF_RST;
      gate_pulse   = GATE_PULSE_RST;
      dly_longest  = DLY_LONGEST_RST;
      dly_shortest = DLY_SHORT_RST;
      prev_level   = 1'b0;
      since_edge   = 0;
      for (int ch = 0; ch < 2; ch++) begin
        phase_cnt[ch] = 0;
        armed[ch]     = 1'b0;
        pulse_cnt[ch] = 0;
      end
      errors   = 0;
      n_ticks  = 0;
      n_edges  = 0;
      n_pulses = 0;
    endfunction

    function void apply_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      logic [BRIGHT_W-1:0] b;
      b = val[BRIGHT_W-1:0];
      if (b > BRIGHT_MAX) b = BRIGHT_MAX;
      case (idx)
        CFG_BRIGHT_CH1:   bright[0]    = b;
        CFG_BRIGHT_CH2:   bright[1]    = b;
        CFG_ZC_HOLDOFF:   holdoff      = val[HOLD_W-1:0];
        CFG_GATE_PULSE:   gate_pulse   = val[PULSE_CFG_W-1:0];
        CFG_DLY_LONGEST:  dly_longest  = val[DLY_W-1:0];
        CFG_DLY_SHORTEST: dly_shortest = val[DLY_W-1:0];
        default: ;
      endcase
    endfunction

    // Linear map from the longest delay (b = 1) to the shortest (b = 100).
    function longint firing_delay(logic [BRIGHT_W-1:0] b);
      longint span;
      if (b == 0) return 0;
      span = longint'(dly_shortest) - longint'(dly_longest);
      return longint'(dly_longest) + ((longint'(b) - 1) * span) / 99;
    endfunction

    function void note_input(logic level);
      tick_out_t exp_beat;
      logic      gate[2];
      bit        accepted;
      accepted = 1'b0;
      if (since_edge < TIME_MAX) since_edge++;
      if (level && !prev_level && since_edge > holdoff) begin
        accepted   = 1'b1;
        since_edge = 0;
        n_edges++;
      end
      prev_level = level;
      for (int ch = 0; ch < 2; ch++) begin
        if (accepted && bright[ch] != 0) begin
          phase_cnt[ch] = 0;
          armed[ch]     = 1'b1;
        end
        if (armed[ch]) begin
          if (longint'(phase_cnt[ch]) >= firing_delay(bright[ch])) begin
            armed[ch] = 1'b0;
            if (bright[ch] != 0) begin
              pulse_cnt[ch] = gate_pulse & PULSE_MAX;
              if (pulse_cnt[ch] != 0) n_pulses++;
            end
          end else if (phase_cnt[ch] < TIME_MAX) begin
            phase_cnt[ch]++;
          end
        end
        gate[ch] = (pulse_cnt[ch] != 0);
        if (pulse_cnt[ch] != 0) pulse_cnt[ch]--;
      end
      exp_beat.gate_one    = gate[0];
      exp_beat.gate_two    = gate[1];
      exp_beat.zc_accepted = accepted;
      pending.push_back(exp_beat);
      n_ticks++;
    endfunction

    task report(string what, logic exp_bit, logic got_bit);
      if (errors < MAX_REPORTS)
        $display("%0t ns mismatch: %s expected %b got %b", $time, what, exp_bit, got_bit);
      errors++;
    endtask

    task check_result(logic gate_one, logic gate_two, logic zc_accepted);
      tick_out_t exp_beat;
      if (pending.size() == 0) begin
        report("result beat with nothing pending, zc_accepted", 1'bx, zc_accepted);
        return;
      end
      exp_beat = pending.pop_front();
      if (gate_one !== exp_beat.gate_one) report("gate_one", exp_beat.gate_one, gate_one);
      if (gate_two !== exp_beat.gate_two) report("gate_two", exp_beat.gate_two, gate_two);
      if (zc_accepted !== exp_beat.zc_accepted)
        report("zc_accepted", exp_beat.zc_accepted, zc_accepted);
    endtask
  endclass

  dimmer_scoreboard sb = new();

  ac_phase_dimmer_two_channel u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .zero_cross_level_i (zero_cross_level_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .gate_one_o         (gate_one_o),
    .gate_two_o         (gate_two_o),
    .zc_accepted_o      (zc_accepted_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Drive tasks
  // --------------------------------------------------------------------------
  task automatic send_tick(input logic level);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_quiet_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    zero_cross_level_i <= level;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(level);
  endtask

  // Leaves the write enable high; close a batch with release_cfg.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.apply_write(idx, val);
  endtask

  task automatic release_cfg();
    cfg_we_i <= 1'b0;
    repeat (2) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic program_all(input logic [CFG_W-1:0] b1, input logic [CFG_W-1:0] b2,
                             input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] pulse,
                             input logic [CFG_W-1:0] dlong, input logic [CFG_W-1:0] dshort);
    write_reg(CFG_BRIGHT_CH1, b1);
    write_reg(CFG_BRIGHT_CH2, b2);
    write_reg(CFG_ZC_HOLDOFF, hold);
    write_reg(CFG_GATE_PULSE, pulse);
    write_reg(CFG_DLY_LONGEST, dlong);
    write_reg(CFG_DLY_SHORTEST, dshort);
    release_cfg();
    settings_run++;
  endtask

  // Square wave with random half periods and occasional flipped samples.
  task automatic drive_mains(input int unsigned n_ticks, input int unsigned half_min,
                             input int unsigned half_max, input int unsigned noise_pct);
    logic        lvl;
    int unsigned run;
    lvl = 1'($urandom_range(1));
    run = 0;
    for (int unsigned t = 0; t < n_ticks; t++) begin
      if (run == 0) begin
        lvl = ~lvl;
        run = $urandom_range(half_max, half_min);
      end
      run--;
      send_tick(($urandom_range(99) < noise_pct) ? ~lvl : lvl);
    end
  endtask

  function automatic logic [CFG_W-1:0] pick_bright();
    case ($urandom_range(4))
      0:       return '0;
      1:       return 14'd1;
      2:       return 14'd100;
      default: return CFG_W'($urandom_range(16383));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_small(input int unsigned hi);
    if ($urandom_range(9) == 0) return CFG_W'($urandom_range(16383));
    return CFG_W'($urandom_range(hi));
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random back-pressure plus one long hold on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i)
        sb.check_result(gate_one_o, gate_two_o, zc_accepted_o);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= receiver_quiet_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned hold_val;
    int unsigned half_lo;
    int unsigned half_hi;
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_index_i        <= '0;
    cfg_wdata_i        <= '0;
    in_valid_i         <= 1'b0;
    zero_cross_level_i <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Start-up: edges inside the first holdoff window are dropped.
    send_tick(1'b0); send_tick(1'b1); send_tick(1'b0); send_tick(1'b1);
    drain();

    // Holdoff at the largest count never lets an edge through.
    write_reg(CFG_ZC_HOLDOFF, 14'h3FFF);
    write_reg(CFG_BRIGHT_CH1, 14'd100);
    release_cfg();
    send_tick(1'b0); send_tick(1'b1); send_tick(1'b0); send_tick(1'b1);
    drain();

    // Brightness above range clamps to 100, giving a zero delay on channel
    // one (fires on the edge tick); channel two sits at the longest delay.
    program_all(14'h3FFF, 14'd1, 14'd0, 14'd3, 14'd2, 14'd0);
    send_tick(1'b0); send_tick(1'b1); send_tick(1'b0); send_tick(1'b0);
    send_tick(1'b0); send_tick(1'b0); send_tick(1'b1); send_tick(1'b1);
    send_tick(1'b0);
    drain();

    // Arm channel two, then disable it mid-count with a zero brightness and a
    // zero pulse width; spare register indexes must change nothing.
    program_all(14'd100, 14'd1, 14'd0, 14'd4, 14'd6, 14'd0);
    send_tick(1'b0); send_tick(1'b1); send_tick(1'b0);
    drain();
    write_reg(CFG_BRIGHT_CH2, 14'd0);
    write_reg(CFG_GATE_PULSE, 14'd0);
    write_reg(IDX_SPARE_LO, 14'h3FFF);
    write_reg(IDX_SPARE_HI, 14'h2AAA);
    release_cfg();
    repeat (5) send_tick(1'b0);
    drain();

    // Random part: one setting per phase, extremes first.
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: program_all(14'd1, 14'd100, 14'd0, 14'd1, 14'd0, 14'd0);
        1: program_all(14'd100, 14'd100, 14'h3FFF, 14'd255, 14'h3FFF, 14'h3FFF);
        2: program_all(14'd100, 14'd50, 14'd20, 14'd255, 14'd30, 14'd2);
        default: program_all(pick_bright(), pick_bright(), pick_small(30), pick_small(12),
                             pick_small(40), pick_small(40));
      endcase
      sender_quiet_pct   = (p == 3) ? 0 : 13;
      receiver_quiet_pct = (p == 3) ? 0 : 13;
      if (p == 5) hold_request = 1'b1;
      hold_val = (sb.holdoff > 40) ? 40 : sb.holdoff;
      half_lo  = hold_val / 4 + 1;
      half_hi  = hold_val / 2 + 10;
      drive_mains(PHASE_TICKS, half_lo, half_hi, (p % 4 == 1) ? 20 : 3);
      drain();
    end

    if (sb.pending.size() != 0)
      sb.report("beats still pending at end, zc_accepted", 1'bx, 1'bx);
    $display("Ran %0d ticks over %0d register settings, including clamped brightness,",
             sb.n_ticks, settings_run);
    $display("zero and maximum holdoff and delays: %0d edges passed, %0d gate pulses.",
             sb.n_edges, sb.n_pulses);
    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
